FILE: rtl/core/lbm_pkg.sv
// Shared types and constants for the RGB layer blend core.
// No dependencies; imported by every module in rtl/core.
package lbm_pkg;

    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int MODE_W     = 3;

    localparam logic [CH_W-1:0] CH_MAX  = 8'd255;
    localparam logic [15:0]     FULL_SQ = 16'd65025;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_OPACITY = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL   = 3'd0,
        MODE_ADD      = 3'd1,
        MODE_SUBTRACT = 3'd2,
        MODE_MULTIPLY = 3'd3,
        MODE_DIVIDE   = 3'd4
    } mode_t;

    // Datapath widths
    localparam int WGT_W = 2 * CH_W;        // alpha * opacity
    localparam int MAG_W = 2 * CH_W;        // |V - b| scaled by the blend denominator
    localparam int NUM_W = WGT_W + MAG_W;   // weight * magnitude
    localparam int DEN_W = 24;              // 65025 * {1, 255, fore}
    localparam int DVD_W = NUM_W + 2;       // 2*num + den
    localparam int DVS_W = DEN_W + 1;       // 2*den
    localparam int Q_W   = CH_W;            // rounded correction
    localparam int QB_W  = $clog2(Q_W);

    localparam int FRONT_STAGES = 3;
    localparam int DIV_STAGES   = Q_W;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES;

    typedef struct packed {
        logic [DVD_W-1:0] rem;
        logic [DVS_W-1:0] dvs;
        logic [Q_W-1:0]   quo;
        logic             neg;
    } div_word_t;

endpackage

FILE: rtl/core/lbm_front.sv
// Per-channel front end: blend value, weighted numerator, denominator, dividend.
// Three register stages; depends on lbm_pkg.
module lbm_front
    import lbm_pkg::*;
(
    input  logic                    clk,
    input  logic [FRONT_STAGES-1:0] stage_en,
    input  logic [MODE_W-1:0]       mode,
    input  logic [CH_W-1:0]         back,
    input  logic [CH_W-1:0]         fore,
    input  logic [WGT_W-1:0]        weight_s1,
    output div_word_t               div_in
);

    typedef enum logic [1:0] {
        DEN_UNIT,
        DEN_MUL,
        DEN_FORE
    } den_sel_t;

    localparam logic [DEN_W-1:0] DEN_UNIT_VAL = DEN_W'(65025);
    localparam logic [DEN_W-1:0] DEN_MUL_VAL  = DEN_W'(65025 * 255);

    // stage 1
    logic [CH_W:0]      sum_add;
    logic [CH_W-1:0]    v_blend;
    logic [MAG_W-1:0]   prod;
    logic               div_exact;
    logic [MAG_W-1:0]   mag_next;
    logic               neg1_next;
    den_sel_t           dsel_next;
    logic [MAG_W-1:0]   mag_reg;
    logic               neg1_reg;
    den_sel_t           dsel_reg;
    logic [CH_W-1:0]    fore1_reg;

    // stage 2
    logic [NUM_W-1:0]   num_next;
    logic [DEN_W-1:0]   den_next;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic               neg2_reg;

    // stage 3
    logic [DVD_W-1:0]   dvd_next;
    logic [DVS_W-1:0]   dvs_next;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic               neg3_reg;

    always_comb
    begin
        prod    = MAG_W'(back) * MAG_W'(CH_MAX - fore);
        sum_add = {1'b0, back} + {1'b0, fore};
        case (mode)
            MODE_ADD:      v_blend = sum_add[CH_W] ? CH_MAX : sum_add[CH_W-1:0];
            MODE_SUBTRACT: v_blend = (back > fore) ? (back - fore) : '0;
            MODE_DIVIDE:   v_blend = CH_MAX;
            default:       v_blend = fore;
        endcase
        div_exact = (mode == MODE_DIVIDE) && (fore != '0) && (back < fore);

        if (mode == MODE_MULTIPLY)
        begin
            // b*(f-255)/255: never positive
            mag_next  = prod;
            neg1_next = 1'b1;
            dsel_next = DEN_MUL;
        end
        else if (div_exact)
        begin
            // b*(255-f)/f
            mag_next  = prod;
            neg1_next = 1'b0;
            dsel_next = DEN_FORE;
        end
        else
        begin
            neg1_next = v_blend < back;
            mag_next  = MAG_W'(neg1_next ? (back - v_blend) : (v_blend - back));
            dsel_next = DEN_UNIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            mag_reg   <= mag_next;
            neg1_reg  <= neg1_next;
            dsel_reg  <= dsel_next;
            fore1_reg <= fore;
        end
    end

    always_comb
    begin
        num_next = NUM_W'(weight_s1) * NUM_W'(mag_reg);
        case (dsel_reg)
            DEN_MUL:  den_next = DEN_MUL_VAL;
            DEN_FORE: den_next = DEN_W'(FULL_SQ) * DEN_W'(fore1_reg);
            default:  den_next = DEN_UNIT_VAL;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            neg2_reg <= neg1_reg;
        end
    end

    // round half up; a negative term rounds toward the upper neighbor too
    assign dvd_next = DVD_W'({num_reg, 1'b0}) + DVD_W'(den_reg) - DVD_W'(neg2_reg);
    assign dvs_next = {den_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            dvd_reg  <= dvd_next;
            dvs_reg  <= dvs_next;
            neg3_reg <= neg2_reg;
        end
    end

    assign div_in.rem = dvd_reg;
    assign div_in.dvs = dvs_reg;
    assign div_in.quo = '0;
    assign div_in.neg = neg3_reg;

endmodule

FILE: rtl/core/lbm_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on lbm_pkg.
module lbm_divider
    import lbm_pkg::*;
(
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] stage_en,
    input  div_word_t             div_in,
    output div_word_t             div_out
);

    div_word_t stage_next [DIV_STAGES];
    div_word_t stage_reg  [DIV_STAGES];

    function automatic div_word_t div_step(input div_word_t w, input logic [QB_W-1:0] pos);
        div_word_t        r;
        logic [DVD_W-1:0] trial;
        r     = w;
        trial = DVD_W'(w.dvs) << pos;
        if (w.rem >= trial)
        begin
            r.rem      = w.rem - trial;
            r.quo[pos] = 1'b1;
        end
        return r;
    endfunction

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_step
        if (g == 0)
        begin : g_first
            assign stage_next[g] = div_step(div_in, QB_W'(Q_W - 1 - g));
        end
        else
        begin : g_rest
            assign stage_next[g] = div_step(stage_reg[g-1], QB_W'(Q_W - 1 - g));
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[g])
                stage_reg[g] <= stage_next[g];
        end
    end

    assign div_out = stage_reg[DIV_STAGES-1];

endmodule

FILE: rtl/core/rgb_layer_blend_with_modes_core.sv
// Top level of the RGB layer blend core: config registers, pipeline control, output stage.
// Depends on lbm_pkg, lbm_front and lbm_divider.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   back_*, fore_*, fore_alpha
//  out      source     out_valid / out_stall out_red, out_green, out_blue
//  cfg      sink       cfg_wr_en             cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_stall stays low; the pipe has 3 front stages,
// 8 divider stages and 1 output register.
// Reset clears the valid bits and loads blend_mode 0, layer_opacity 255.
// Stall moves back stage by stage: empty stages keep filling while the
// output register holds, and in_stall rises only when every stage is full.
module rgb_layer_blend_with_modes_core
    import lbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CH_W-1:0]       back_red,
    input  logic [CH_W-1:0]       back_green,
    input  logic [CH_W-1:0]       back_blue,
    input  logic [CH_W-1:0]       fore_red,
    input  logic [CH_W-1:0]       fore_green,
    input  logic [CH_W-1:0]       fore_blue,
    input  logic [CH_W-1:0]       fore_alpha,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CH_W-1:0]       out_red,
    output logic [CH_W-1:0]       out_green,
    output logic [CH_W-1:0]       out_blue
);

    typedef enum logic [1:0] {
        SEL_BACK,
        SEL_FORE,
        SEL_MIX
    } pix_sel_t;

    typedef struct packed {
        pix_sel_t                      sel;
        logic [NUM_CH-1:0][CH_W-1:0]   back;
        logic [NUM_CH-1:0][CH_W-1:0]   fore;
    } pix_ctl_t;

    logic [MODE_W-1:0]           mode_reg;
    logic [CH_W-1:0]             opacity_reg;

    logic [NUM_STAGES:0]         rdy;
    logic [NUM_STAGES-1:0]       valid_next;
    logic [NUM_STAGES-1:0]       valid_reg;
    logic                        out_valid_reg;

    logic [NUM_CH-1:0][CH_W-1:0] back_in;
    logic [NUM_CH-1:0][CH_W-1:0] fore_in;
    pix_ctl_t                    ctl_next;
    pix_ctl_t                    ctl_reg [NUM_STAGES];
    logic [WGT_W-1:0]            weight_next;
    logic [WGT_W-1:0]            weight_reg;

    div_word_t                   front_out [NUM_CH];
    div_word_t                   div_out   [NUM_CH];

    logic [NUM_CH-1:0][CH_W-1:0] pix_next;
    logic [NUM_CH-1:0][CH_W-1:0] pix_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            opacity_reg <= CH_MAX;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BLEND_MODE:    mode_reg    <= cfg_wdata[MODE_W-1:0];
                REG_LAYER_OPACITY: opacity_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // pipeline flow control
    always_comb
    begin
        rdy[NUM_STAGES] = !out_valid_reg || !out_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
            rdy[k] = !valid_reg[k] || rdy[k+1];
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (!rdy[k])
                valid_next[k] = valid_reg[k];
            else if (k == 0)
                valid_next[k] = in_valid;
            else
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rdy[NUM_STAGES])
                out_valid_reg <= valid_reg[NUM_STAGES-1];
        end
    end

    assign in_stall = !rdy[0];

    // stage 0: transaction decode and layer weight
    assign back_in = {back_blue, back_green, back_red};
    assign fore_in = {fore_blue, fore_green, fore_red};

    always_comb
    begin
        ctl_next.back = back_in;
        ctl_next.fore = fore_in;
        if (fore_alpha == '0 || mode_reg > MODE_DIVIDE)
            ctl_next.sel = SEL_BACK;
        else if (mode_reg == MODE_NORMAL && fore_alpha == CH_MAX)
            ctl_next.sel = SEL_FORE;
        else
            ctl_next.sel = SEL_MIX;
        weight_next = WGT_W'(fore_alpha) * WGT_W'(opacity_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ctl_reg[0] <= ctl_next;
            weight_reg <= weight_next;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (rdy[k])
                ctl_reg[k] <= ctl_reg[k-1];
        end
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_chan
        lbm_front u_front (
            .clk       (clk),
            .stage_en  (rdy[FRONT_STAGES-1:0]),
            .mode      (mode_reg),
            .back      (back_in[c]),
            .fore      (fore_in[c]),
            .weight_s1 (weight_reg),
            .div_in    (front_out[c])
        );

        lbm_divider u_divider (
            .clk      (clk),
            .stage_en (rdy[NUM_STAGES-1:FRONT_STAGES]),
            .div_in   (front_out[c]),
            .div_out  (div_out[c])
        );
    end

    // output stage: b +/- rounded correction, or a bypass
    always_comb
    begin
        logic [CH_W:0] sum;
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum = {1'b0, ctl_reg[NUM_STAGES-1].back[c]} + {1'b0, div_out[c].quo};
            case (ctl_reg[NUM_STAGES-1].sel)
                SEL_BACK: pix_next[c] = ctl_reg[NUM_STAGES-1].back[c];
                SEL_FORE: pix_next[c] = ctl_reg[NUM_STAGES-1].fore[c];
                default:
                begin
                    if (div_out[c].neg)
                        pix_next[c] = (div_out[c].quo > ctl_reg[NUM_STAGES-1].back[c]) ? '0 :
                                      ctl_reg[NUM_STAGES-1].back[c] - div_out[c].quo;
                    else
                        pix_next[c] = sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NUM_STAGES])
            pix_reg <= pix_next;
    end

    assign out_valid = out_valid_reg;
    assign out_red   = pix_reg[0];
    assign out_green = pix_reg[1];
    assign out_blue  = pix_reg[2];

endmodule

FILE: rtl/core/lbm_checker.sv
// Port-level checks for rgb_layer_blend_with_modes_core, bound to the top level.
// Depends on lbm_pkg and the top-level port list.
module lbm_checker
    import lbm_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_stall,
    input logic            out_valid,
    input logic            out_stall,
    input logic [CH_W-1:0] out_red,
    input logic [CH_W-1:0] out_green,
    input logic [CH_W-1:0] out_blue
);

    // input back-pressure only when the whole pipe is backed up by a stalled output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled output transaction");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid on the first cycle after reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_red)
                                      && $stable(out_green) && $stable(out_blue)))
        else $error("stalled output transaction changed or dropped");

endmodule

bind rgb_layer_blend_with_modes_core lbm_checker u_lbm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
);

FILE: tb/sv/rgb_blend_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the RGB layer blend core: tracks config writes, predicts each accepted pixel
// and compares it with the output transactions in order. Depends on lbm_pkg.
module rgb_blend_checker
    import lbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [CH_W-1:0]       back_red,
    input  logic [CH_W-1:0]       back_green,
    input  logic [CH_W-1:0]       back_blue,
    input  logic [CH_W-1:0]       fore_red,
    input  logic [CH_W-1:0]       fore_green,
    input  logic [CH_W-1:0]       fore_blue,
    input  logic [CH_W-1:0]       fore_alpha,

    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [CH_W-1:0]       out_red,
    input  logic [CH_W-1:0]       out_green,
    input  logic [CH_W-1:0]       out_blue,

    output int                    mismatch_count,
    output int                    pixels_in_flight
);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_pixel_t;

    localparam int MAX_REPORTS = 10;

    logic [MODE_W-1:0] mode_reg;
    logic [CH_W-1:0]   opacity_reg;
    rgb_pixel_t        expected_pixels[$];

    function automatic logic [CH_W-1:0] blend_channel(input logic [MODE_W-1:0] mode,
                                                      input logic [CH_W-1:0]   b,
                                                      input logic [CH_W-1:0]   f,
                                                      input logic [WGT_W-1:0]  w);
        longint unsigned bb;
        longint unsigned ff;
        longint unsigned ww;
        longint unsigned vn;
        longint unsigned vd;
        longint unsigned num;
        longint unsigned den;
        longint unsigned r;
        bb = b;
        ff = f;
        ww = w;
        vd = 1;
        case (mode)
            MODE_ADD:
            begin
                vn = bb + ff;
                if (vn > CH_MAX)
                    vn = CH_MAX;
            end
            MODE_SUBTRACT:
                vn = (bb > ff) ? bb - ff : 0;
            MODE_MULTIPLY:
            begin
                vn = bb * ff;
                vd = CH_MAX;
            end
            MODE_DIVIDE:
            begin
                if (ff == 0 || bb >= ff)
                    vn = CH_MAX;
                else
                begin
                    vn = CH_MAX * bb;
                    vd = ff;
                end
            end
            default:
                vn = ff;
        endcase
        den = longint'(FULL_SQ) * vd;
        num = bb * (longint'(FULL_SQ) - ww) * vd + vn * ww;
        r = (2 * num + den) / (2 * den);
        if (r > CH_MAX)
            r = CH_MAX;
        return r[CH_W-1:0];
    endfunction

    function automatic rgb_pixel_t expected_blend(input logic [MODE_W-1:0] mode,
                                                  input logic [CH_W-1:0]   opacity,
                                                  input logic [CH_W-1:0]   br,
                                                  input logic [CH_W-1:0]   bg,
                                                  input logic [CH_W-1:0]   bb,
                                                  input logic [CH_W-1:0]   fr,
                                                  input logic [CH_W-1:0]   fg,
                                                  input logic [CH_W-1:0]   fb,
                                                  input logic [CH_W-1:0]   alpha);
        rgb_pixel_t      p;
        logic [WGT_W-1:0] w;
        w = WGT_W'(alpha) * WGT_W'(opacity);
        // transparent layer or undefined mode: background passes through
        if (alpha == 0 || mode > MODE_DIVIDE)
            p = '{br, bg, bb};
        // opaque normal layer ignores opacity
        else if (mode == MODE_NORMAL && alpha == CH_MAX)
            p = '{fr, fg, fb};
        else
            p = '{blend_channel(mode, br, fr, w),
                  blend_channel(mode, bg, fg, w),
                  blend_channel(mode, bb, fb, w)};
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgb_pixel_t got;
        rgb_pixel_t want;
        if (!rst_n)
        begin
            mode_reg         <= MODE_NORMAL;
            opacity_reg      <= CH_MAX;
            mismatch_count   <= 0;
            pixels_in_flight <= 0;
            expected_pixels.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{out_red, out_green, out_blue};
                if (expected_pixels.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: unexpected output transaction r %0d g %0d b %0d",
                                 $realtime, got.red, got.green, got.blue);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.red != want.red || got.green != want.green
                        || got.blue != want.blue)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                            $display("%0t: mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     $realtime, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_pixels.push_back(expected_blend(mode_reg, opacity_reg,
                                                         back_red, back_green, back_blue,
                                                         fore_red, fore_green, fore_blue,
                                                         fore_alpha));
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_BLEND_MODE:    mode_reg    <= cfg_wdata[MODE_W-1:0];
                    REG_LAYER_OPACITY: opacity_reg <= cfg_wdata;
                    default:           ;
                endcase
            end
            pixels_in_flight <= expected_pixels.size();
        end
    end

endmodule

FILE: tb/sv/rgb_layer_blend_with_modes_core_tb.sv
`timescale 1ns / 100ps
// Top of the RGB layer blend testbench: clock, reset, config writes and pixel stimulus.
// Depends on lbm_pkg, rgb_layer_blend_with_modes_core and rgb_blend_checker.
module rgb_layer_blend_with_modes_core_tb;
    import lbm_pkg::*;

    typedef struct {
        logic [CH_W-1:0] back_red;
        logic [CH_W-1:0] back_green;
        logic [CH_W-1:0] back_blue;
        logic [CH_W-1:0] fore_red;
        logic [CH_W-1:0] fore_green;
        logic [CH_W-1:0] fore_blue;
        logic [CH_W-1:0] fore_alpha;
    } layer_pixel_t;

    localparam int                RANDOM_ITEMS     = 800;
    localparam int                WATCHDOG_LIMIT   = 4000;
    localparam int                TAIL_CYCLES      = 2 * (NUM_STAGES + 1);
    localparam logic [MODE_W-1:0] MODE_UNDEF_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNDEF_LAST  = 3'd7;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_BLEND_MODE;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [CH_W-1:0]       back_red   = '0;
    logic [CH_W-1:0]       back_green = '0;
    logic [CH_W-1:0]       back_blue  = '0;
    logic [CH_W-1:0]       fore_red   = '0;
    logic [CH_W-1:0]       fore_green = '0;
    logic [CH_W-1:0]       fore_blue  = '0;
    logic [CH_W-1:0]       fore_alpha = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [CH_W-1:0]       out_red;
    logic [CH_W-1:0]       out_green;
    logic [CH_W-1:0]       out_blue;

    int mismatch_count;
    int pixels_in_flight;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int idle_cycles = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    rgb_layer_blend_with_modes_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .back_red   (back_red),
        .back_green (back_green),
        .back_blue  (back_blue),
        .fore_red   (fore_red),
        .fore_green (fore_green),
        .fore_blue  (fore_blue),
        .fore_alpha (fore_alpha),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue)
    );

    rgb_blend_checker u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .back_red         (back_red),
        .back_green       (back_green),
        .back_blue        (back_blue),
        .fore_red         (fore_red),
        .fore_green       (fore_green),
        .fore_blue        (fore_blue),
        .fore_alpha       (fore_alpha),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_red          (out_red),
        .out_green        (out_green),
        .out_blue         (out_blue),
        .mismatch_count   (mismatch_count),
        .pixels_in_flight (pixels_in_flight)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < rx_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic layer_pixel_t make_pixel(input logic [CH_W-1:0] br, bg, bb,
                                                input logic [CH_W-1:0] fr, fg, fb,
                                                input logic [CH_W-1:0] alpha);
        layer_pixel_t p;
        p = '{br, bg, bb, fr, fg, fb, alpha};
        return p;
    endfunction

    function automatic logic [CH_W-1:0] rand_channel();
        case ($urandom_range(15))
            0:       return '0;
            1:       return CH_MAX;
            default: return CH_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] rand_alpha();
        case ($urandom_range(7))
            0:       return '0;
            1:       return CH_MAX;
            default: return CH_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixel(input layer_pixel_t p);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        back_red   <= p.back_red;
        back_green <= p.back_green;
        back_blue  <= p.back_blue;
        fore_red   <= p.fore_red;
        fore_green <= p.fore_green;
        fore_blue  <= p.fore_blue;
        fore_alpha <= p.fore_alpha;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // hold off the sender until every predicted pixel has come out
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pixels_in_flight != 0);
    endtask

    task automatic apply_settings(input logic [MODE_W-1:0] mode, input logic [CH_W-1:0] opacity);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BLEND_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(posedge clk);
        cfg_index <= REG_LAYER_OPACITY;
        cfg_wdata <= opacity;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int                phase;
        int                sent;
        int                seg_len;
        int                i;
        logic [MODE_W-1:0] mode;
        logic [CH_W-1:0]   opacity;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: normal mode, fully opaque layer
        send_pixel(make_pixel(8'd10, 8'd20, 8'd30, 8'd200, 8'd210, 8'd220, 8'd0));
        send_pixel(make_pixel(8'd10, 8'd20, 8'd30, 8'd200, 8'd210, 8'd220, CH_MAX));
        send_pixel(make_pixel(8'd0, 8'd128, CH_MAX, CH_MAX, 8'd64, 8'd0, 8'd128));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1));
        send_pixel(make_pixel(CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX, 8'd254));

        apply_settings(MODE_NORMAL, 8'd0);
        send_pixel(make_pixel(8'd1, 8'd2, 8'd3, 8'd250, 8'd251, 8'd252, CH_MAX));
        send_pixel(make_pixel(8'd1, 8'd2, 8'd3, 8'd250, 8'd251, 8'd252, 8'd100));

        apply_settings(MODE_ADD, CH_MAX);
        send_pixel(make_pixel(8'd200, 8'd0, CH_MAX, 8'd100, 8'd0, CH_MAX, CH_MAX));
        send_pixel(make_pixel(8'd200, 8'd50, 8'd7, 8'd100, 8'd60, 8'd9, 8'd1));

        apply_settings(MODE_SUBTRACT, 8'd200);
        send_pixel(make_pixel(8'd10, 8'd200, CH_MAX, 8'd200, 8'd10, CH_MAX, CH_MAX));
        send_pixel(make_pixel(8'd0, 8'd99, 8'd128, CH_MAX, 8'd1, 8'd127, 8'd170));

        apply_settings(MODE_MULTIPLY, CH_MAX);
        send_pixel(make_pixel(CH_MAX, 8'd128, 8'd0, CH_MAX, 8'd2, CH_MAX, CH_MAX));
        send_pixel(make_pixel(8'd77, 8'd128, 8'd201, 8'd33, 8'd129, 8'd255, 8'd77));

        // divide: zero foreground, background at or above foreground, below foreground
        apply_settings(MODE_DIVIDE, CH_MAX);
        send_pixel(make_pixel(8'd100, 8'd200, 8'd3, 8'd0, 8'd150, 8'd200, CH_MAX));
        send_pixel(make_pixel(8'd0, 8'd1, 8'd254, 8'd0, CH_MAX, CH_MAX, 8'd128));

        apply_settings(MODE_DIVIDE, 8'd1);
        send_pixel(make_pixel(8'd5, 8'd1, 8'd254, 8'd0, CH_MAX, CH_MAX, CH_MAX));

        apply_settings(MODE_UNDEF_FIRST, 8'd128);
        send_pixel(make_pixel(8'd11, 8'd22, 8'd33, 8'd44, 8'd55, 8'd66, CH_MAX));

        apply_settings(MODE_UNDEF_LAST, CH_MAX);
        send_pixel(make_pixel(CH_MAX, 8'd0, 8'd170, 8'd0, CH_MAX, 8'd85, 8'd200));

        for (phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 79 : 0;
            rx_idle_pct <= (phase == 0) ? 79 : (phase == 1) ? 26 : 0;
            sent = 0;
            while (sent < RANDOM_ITEMS / 3)
            begin
                if ($urandom_range(9) == 0)
                    mode = MODE_W'($urandom_range(MODE_UNDEF_FIRST, MODE_UNDEF_LAST));
                else
                    mode = MODE_W'($urandom_range(MODE_NORMAL, MODE_DIVIDE));
                case ($urandom_range(3))
                    0:       opacity = '0;
                    1:       opacity = CH_MAX;
                    default: opacity = CH_W'($urandom_range(255));
                endcase
                apply_settings(mode, opacity);
                seg_len = $urandom_range(20, 60);
                if (seg_len > RANDOM_ITEMS / 3 - sent)
                    seg_len = RANDOM_ITEMS / 3 - sent;
                for (i = 0; i < seg_len; i++)
                begin
                    if (i == seg_len / 2)
                        drain();
                    send_pixel(make_pixel(rand_channel(), rand_channel(), rand_channel(),
                                          rand_channel(), rand_channel(), rand_channel(),
                                          rand_alpha()));
                end
                sent += seg_len;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pixels_in_flight == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
